/* src/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, constants and helpers of the separator/space tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned INDEX_W   = 16;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DAT_W = 64;

   localparam int unsigned SEP_SLOTS   = 8;
   localparam int unsigned SPACE_SLOTS = 4;
   localparam int unsigned SEP_CNT_W   = 4;
   localparam int unsigned SPACE_CNT_W = 3;

   // up to this many results per request
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned RES_PTR_W   = $clog2(MAX_RESULTS);
   localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam longint unsigned MAX_SYMBOLS = 64'd65536;
   localparam logic [INDEX_W-1:0] INDEX_CAP =
      (MAX_SYMBOLS - 64'd1 < 64'd65535) ? INDEX_W'(MAX_SYMBOLS - 64'd1)
                                        : {INDEX_W{1'b1}};

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_WORD_BYTE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WORD_END  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEPARATOR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SPACE     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LINE_MARK = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_CHARS   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_COUNT   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_CHARS = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_COUNT = 8'd3;

   localparam logic [SEP_SLOTS*BYTE_W-1:0]   SEP_CHARS_RST   = '0;
   localparam logic [SEP_CNT_W-1:0]          SEP_COUNT_RST   = '0;
   localparam logic [SPACE_SLOTS*BYTE_W-1:0] SPACE_CHARS_RST = 32'd32;
   localparam logic [SPACE_CNT_W-1:0]        SPACE_COUNT_RST = 3'd1;

   typedef struct packed {
      logic is_space;
      logic is_sep;
   } sst_class_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  byte_value;
      logic [INDEX_W-1:0] symbol_index;
   } sst_result_type;

   // saturating token index step
   function automatic logic [INDEX_W-1:0] bump_index(input logic [INDEX_W-1:0] value);
      bump_index = (value < INDEX_CAP) ? value + INDEX_W'(1) : value;
   endfunction

endpackage

/* src/sst_if.sv */
// ----------------------------------------------------------------------------
// sst channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface sst_req_if;
   logic                        valid;
   logic                        ready;
   logic [sst_pkg::BYTE_W-1:0]  char_byte;
   logic                        final_byte;

   modport source (output valid, char_byte, final_byte, input ready);
   modport sink   (input valid, char_byte, final_byte, output ready);
endinterface

interface sst_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sst_pkg::KIND_W-1:0]  kind;
   logic [sst_pkg::BYTE_W-1:0]  byte_value;
   logic [sst_pkg::INDEX_W-1:0] symbol_index;
   logic                        last_of_item;

   modport source (output valid, kind, byte_value, symbol_index, last_of_item,
                   input ready);
   modport sink   (input valid, kind, byte_value, symbol_index, last_of_item,
                   output ready);
endinterface

interface sst_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sst_pkg::CSR_IDX_W-1:0] reg_index;
   logic [sst_pkg::CSR_DAT_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* src/sst_classify.sv */
// ----------------------------------------------------------------------------
// sst_classify
// Matches one byte against the packed separator and space sets.
// ----------------------------------------------------------------------------
module sst_classify (
   input  logic [sst_pkg::BYTE_W-1:0]                        char_byte,
   input  logic [sst_pkg::SEP_SLOTS*sst_pkg::BYTE_W-1:0]     sep_chars,
   input  logic [sst_pkg::SEP_CNT_W-1:0]                     sep_count,
   input  logic [sst_pkg::SPACE_SLOTS*sst_pkg::BYTE_W-1:0]   space_chars,
   input  logic [sst_pkg::SPACE_CNT_W-1:0]                   space_count,
   output sst_pkg::sst_class_type                            cls
);
   import sst_pkg::*;

   logic [SEP_SLOTS-1:0]   sep_hit;
   logic [SPACE_SLOTS-1:0] space_hit;

   // a count above the slot number simply enables every slot
   always_comb begin
      for (int i = 0; i < SEP_SLOTS; i++) begin
         sep_hit[i] = (SEP_CNT_W'(i) < sep_count) &&
                      (sep_chars[i*BYTE_W +: BYTE_W] == char_byte);
      end
      for (int i = 0; i < SPACE_SLOTS; i++) begin
         space_hit[i] = (SPACE_CNT_W'(i) < space_count) &&
                        (space_chars[i*BYTE_W +: BYTE_W] == char_byte);
      end
   end

   assign cls.is_space = |space_hit;
   assign cls.is_sep   = |sep_hit;

endmodule

/* src/separator_space_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// separator_space_tokenizer_unit
// Byte-stream tokenizer with configurable separator and space sets.
// ----------------------------------------------------------------------------
// Each request (one content byte) is registered, classified and expanded into
// zero to four results, which leave one per cycle from a small result buffer
// while the result channel is ready. A byte that yields one result sustains
// one request per clock while the result channel is ready; a byte yielding
// more results holds the result channel until its last result is taken, and
// the next request waits in the input register meanwhile. A repeated space
// yields no result. Registers may be written only while the block is idle.
module separator_space_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   sst_req_if.sink    req_chan,
   sst_rsp_if.source  rsp_chan,
   sst_csr_if.sink    csr_chan
);
   import sst_pkg::*;

   // configuration
   logic [SEP_SLOTS*BYTE_W-1:0]   sep_chars_ff;
   logic [SEP_CNT_W-1:0]          sep_count_ff;
   logic [SPACE_SLOTS*BYTE_W-1:0] space_chars_ff;
   logic [SPACE_CNT_W-1:0]        space_count_ff;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_final_ff;

   // tokenizer state
   logic               word_open_ff, word_open_in;
   logic               in_space_run_ff, in_space_run_in;
   logic [INDEX_W-1:0] token_count_ff, token_count_in;
   logic [INDEX_W-1:0] last_mark_ff, last_mark_in;
   logic               mark_recorded_ff, mark_recorded_in;

   // result buffer
   sst_result_type       res_ff [MAX_RESULTS];
   sst_result_type       res_in [MAX_RESULTS];
   logic [RES_CNT_W-1:0] res_n_ff, res_n_in;
   logic [RES_PTR_W-1:0] res_ptr_ff;

   sst_class_type cls;
   logic          buf_valid;
   logic          out_last;
   logic          buf_free;
   logic          process;
   logic          req_take;
   logic          rsp_take;

   sst_classify u_classify (
      .char_byte   (in_byte_ff),
      .sep_chars   (sep_chars_ff),
      .sep_count   (sep_count_ff),
      .space_chars (space_chars_ff),
      .space_count (space_count_ff),
      .cls         (cls)
   );

   assign buf_valid = (res_n_ff != '0);
   assign out_last  = ({1'b0, res_ptr_ff} + RES_CNT_W'(1)) == res_n_ff;
   assign rsp_take  = buf_valid && rsp_chan.ready;
   assign buf_free  = !buf_valid || (rsp_chan.ready && out_last);
   assign process   = in_valid_ff && buf_free;
   assign req_take  = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || process;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = buf_valid;
   assign rsp_chan.kind         = res_ff[res_ptr_ff].kind;
   assign rsp_chan.byte_value   = res_ff[res_ptr_ff].byte_value;
   assign rsp_chan.symbol_index = res_ff[res_ptr_ff].symbol_index;
   assign rsp_chan.last_of_item = out_last;

   // expand the registered byte into its result list and next state
   always_comb begin
      logic [RES_CNT_W-1:0] n;
      logic                 is_nl;
      n                = '0;
      is_nl            = (in_byte_ff == NEWLINE_BYTE);
      word_open_in     = word_open_ff;
      in_space_run_in  = in_space_run_ff;
      token_count_in   = token_count_ff;
      last_mark_in     = last_mark_ff;
      mark_recorded_in = mark_recorded_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_in[i] = '0;
      end

      // mark comes first and carries the count from before this byte
      if (is_nl) begin
         res_in[n[RES_PTR_W-1:0]] = '{KIND_LINE_MARK, '0, token_count_in};
         n                = n + RES_CNT_W'(1);
         last_mark_in     = token_count_in;
         mark_recorded_in = 1'b1;
      end

      if (cls.is_space || cls.is_sep) begin
         if (word_open_in) begin
            res_in[n[RES_PTR_W-1:0]] = '{KIND_WORD_END, '0, token_count_in};
            n               = n + RES_CNT_W'(1);
            token_count_in  = bump_index(token_count_in);
            word_open_in    = 1'b0;
            in_space_run_in = 1'b0;
         end
         // a byte in both sets counts as a space
         if (!cls.is_space) begin
            in_space_run_in = 1'b0;
            res_in[n[RES_PTR_W-1:0]] = '{KIND_SEPARATOR, in_byte_ff, token_count_in};
            n              = n + RES_CNT_W'(1);
            token_count_in = bump_index(token_count_in);
         end else if (!in_space_run_in) begin
            in_space_run_in = 1'b1;
            res_in[n[RES_PTR_W-1:0]] = '{KIND_SPACE, '0, token_count_in};
            n              = n + RES_CNT_W'(1);
            token_count_in = bump_index(token_count_in);
         end
      end else begin
         res_in[n[RES_PTR_W-1:0]] = '{KIND_WORD_BYTE, in_byte_ff, token_count_in};
         n            = n + RES_CNT_W'(1);
         word_open_in = 1'b1;
         if (in_final_ff) begin
            res_in[n[RES_PTR_W-1:0]] = '{KIND_WORD_END, '0, token_count_in};
            n               = n + RES_CNT_W'(1);
            token_count_in  = bump_index(token_count_in);
            word_open_in    = 1'b0;
            in_space_run_in = 1'b0;
         end
      end

      // closing mark, then clear for the next content
      if (in_final_ff) begin
         if (!mark_recorded_in || (last_mark_in != token_count_in)) begin
            res_in[n[RES_PTR_W-1:0]] = '{KIND_LINE_MARK, '0, token_count_in};
            n = n + RES_CNT_W'(1);
         end
         word_open_in     = 1'b0;
         in_space_run_in  = 1'b0;
         token_count_in   = '0;
         last_mark_in     = '0;
         mark_recorded_in = 1'b0;
      end

      res_n_in = n;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_chars_ff   <= SEP_CHARS_RST;
         sep_count_ff   <= SEP_COUNT_RST;
         space_chars_ff <= SPACE_CHARS_RST;
         space_count_ff <= SPACE_COUNT_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CSR_SEP_CHARS: begin
               sep_chars_ff <= csr_chan.wdata;
            end
            CSR_SEP_COUNT: begin
               sep_count_ff <= csr_chan.wdata[SEP_CNT_W-1:0];
            end
            CSR_SPACE_CHARS: begin
               space_chars_ff <= csr_chan.wdata[SPACE_SLOTS*BYTE_W-1:0];
            end
            CSR_SPACE_COUNT: begin
               space_count_ff <= csr_chan.wdata[SPACE_CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_chan.char_byte;
         in_final_ff <= req_chan.final_byte;
      end
   end

   // tokenizer state and result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         word_open_ff     <= 1'b0;
         in_space_run_ff  <= 1'b0;
         token_count_ff   <= '0;
         last_mark_ff     <= '0;
         mark_recorded_ff <= 1'b0;
         res_n_ff         <= '0;
         res_ptr_ff       <= '0;
      end else if (process) begin
         word_open_ff     <= word_open_in;
         in_space_run_ff  <= in_space_run_in;
         token_count_ff   <= token_count_in;
         last_mark_ff     <= last_mark_in;
         mark_recorded_ff <= mark_recorded_in;
         res_n_ff         <= res_n_in;
         res_ptr_ff       <= '0;
      end else if (rsp_take) begin
         if (out_last) begin
            res_n_ff   <= '0;
            res_ptr_ff <= '0;
         end else begin
            res_ptr_ff <= res_ptr_ff + RES_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

endmodule
